### hdl/sngh_pkg.sv
package sngh_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_W      = 24;
  localparam int GAIN_W      = 24;
  localparam int LEVEL_W     = 24;
  localparam int HOLD_W      = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [GAIN_W-1:0]  UNITY_GAIN      = 24'd8388608;
  localparam logic [COEF_W-1:0]  BYPASS_COEF_DEF = 24'd16707642;
  localparam int                 QUEUE_DEPTH_DEF = 2;

  localparam logic [LEVEL_W-1:0] CLOSE_LEVEL_RST  = 24'd8389;
  localparam logic [LEVEL_W-1:0] OPEN_LEVEL_RST   = 24'd11850;
  localparam logic [HOLD_W-1:0]  HOLD_FRAMES_RST  = 20'd0;
  localparam logic [COEF_W-1:0]  FADE_OUT_RST     = 24'd16742315;
  localparam logic [COEF_W-1:0]  FADE_IN_RST      = 24'd16775468;
  localparam logic [COEF_W-1:0]  DET_ATTACK_RST   = 24'd16437282;
  localparam logic [COEF_W-1:0]  DET_RELEASE_RST  = 24'd16742315;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SAMPLE_BITS-1:0]        mag_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } in_beat_t;

  typedef struct packed {
    sample_t           left_out;
    sample_t           right_out;
    logic [GAIN_W-1:0] gain_now;
    logic              is_open;
  } out_beat_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    mag_t    det;
  } work_t;

  typedef struct packed {
    logic               gate_enable;
    logic [LEVEL_W-1:0] close_level;
    logic [LEVEL_W-1:0] open_level;
    logic [HOLD_W-1:0]  hold_frames;
    logic [COEF_W-1:0]  fade_out_coef;
    logic [COEF_W-1:0]  fade_in_coef;
    logic [COEF_W-1:0]  detector_attack_coef;
    logic [COEF_W-1:0]  detector_release_coef;
  } cfg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GATE_ENABLE,
    CFG_CLOSE_LEVEL,
    CFG_OPEN_LEVEL,
    CFG_HOLD_FRAMES,
    CFG_FADE_OUT_COEF,
    CFG_FADE_IN_COEF,
    CFG_DET_ATTACK_COEF,
    CFG_DET_RELEASE_COEF
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENVUPD,
    S_GATE,
    S_GAIN,
    S_GAINUPD,
    S_LEFT,
    S_RIGHT,
    S_OUT
  } back_state_t;

endpackage

### hdl/sngh_front.sv
module sngh_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sngh_pkg::in_beat_t in_data,
  output logic               q_valid,
  input  logic               q_ready,
  output sngh_pkg::work_t    q_data
);
  import sngh_pkg::*;

  logic  st_valid;
  work_t st;
  mag_t  mag_l;
  mag_t  mag_r;

  // full-scale negative wraps to 2^(N-1), which is the right magnitude unsigned
  assign mag_l = in_data.left_in[SAMPLE_BITS-1]  ? mag_t'(-in_data.left_in)  : mag_t'(in_data.left_in);
  assign mag_r = in_data.right_in[SAMPLE_BITS-1] ? mag_t'(-in_data.right_in) : mag_t'(in_data.right_in);

  assign in_ready = !st_valid || q_ready;
  assign q_valid  = st_valid;
  assign q_data   = st;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      st_valid <= 1'b1;
    end else if (q_ready) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st.left  <= in_data.left_in;
      st.right <= in_data.right_in;
      st.det   <= (mag_l > mag_r) ? mag_l : mag_r;
    end
  end

endmodule

### hdl/sngh_fifo.sv
module sngh_fifo #(
  parameter int DEPTH = sngh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  sngh_pkg::work_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output sngh_pkg::work_t pop_data
);
  import sngh_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  work_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

### hdl/sngh_back.sv
module sngh_back #(
  parameter logic [sngh_pkg::COEF_W-1:0] BYPASS_COEF = sngh_pkg::BYPASS_COEF_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  sngh_pkg::cfg_t      cfg,
  input  logic                q_valid,
  output logic                q_ready,
  input  sngh_pkg::work_t     q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sngh_pkg::out_beat_t out_data
);
  import sngh_pkg::*;

  localparam int A_W    = COEF_W + 1;
  localparam int B_W    = ((SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W) + 1;
  localparam int CMP_W  = B_W - 1;
  localparam int PROD_W = A_W + B_W;
  localparam logic signed [PROD_W-1:0] HALF24 = {{(PROD_W-24){1'b0}}, 1'b1, 23'd0};
  localparam logic signed [PROD_W-1:0] HALF23 = {{(PROD_W-23){1'b0}}, 1'b1, 22'd0};
  localparam logic signed [B_W-1:0]    UNITY_B = {{(B_W-GAIN_W){1'b0}}, UNITY_GAIN};

  back_state_t state, state_next;

  work_t                     cur;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [A_W-1:0]     mul_a;
  logic signed [B_W-1:0]     mul_b;
  mag_t                      env;
  logic [GAIN_W-1:0]         gain;
  logic [HOLD_W-1:0]         below_cnt;
  logic                      open_flag;
  logic                      tgt_unity;
  logic [COEF_W-1:0]         coef_r;
  sample_t                   lout;

  logic signed [PROD_W-1:0]  sum24;
  logic signed [PROD_W-1:0]  sum23;
  logic signed [PROD_W-1:0]  rs24;
  logic signed [PROD_W-1:0]  rs23;
  logic signed [B_W-1:0]     env_sum;
  logic signed [B_W-1:0]     gain_sum;
  logic signed [B_W-1:0]     tgt_b;
  logic [GAIN_W-1:0]         gain_new;
  logic [CMP_W-1:0]          env_c;
  logic [CMP_W-1:0]          open_c;
  logic [CMP_W-1:0]          close_c;
  logic [HOLD_W-1:0]         cnt_inc;
  logic [HOLD_W-1:0]         cnt_next;
  logic                      open_next;
  logic [COEF_W-1:0]         coef_next;
  logic                      load_out;

  // shared multiplier
  assign prod_next = mul_a * mul_b;

  assign sum24 = prod + HALF24;
  assign sum23 = prod + HALF23;
  assign rs24  = sum24 >>> 24;
  assign rs23  = sum23 >>> 23;

  assign env_sum  = $signed({{(B_W-SAMPLE_BITS){1'b0}}, cur.det}) + rs24[B_W-1:0];
  assign tgt_b    = tgt_unity ? UNITY_B : '0;
  assign gain_sum = tgt_b + rs24[B_W-1:0];

  always_comb begin
    if (gain_sum[B_W-1]) begin
      gain_new = '0;
    end else if (gain_sum > UNITY_B) begin
      gain_new = UNITY_GAIN;
    end else begin
      gain_new = gain_sum[GAIN_W-1:0];
    end
  end

  // gate decision on the updated envelope
  assign env_c   = CMP_W'(env);
  assign open_c  = CMP_W'(cfg.open_level);
  assign close_c = CMP_W'(cfg.close_level);
  assign cnt_inc = (below_cnt < cfg.hold_frames) ? below_cnt + 1'b1 : below_cnt;

  always_comb begin
    open_next = open_flag;
    cnt_next  = below_cnt;
    coef_next = BYPASS_COEF;
    if (cfg.gate_enable) begin
      if (!open_flag) begin
        if (env_c >= open_c) begin
          open_next = 1'b1;
          cnt_next  = '0;
        end
      end else if (env_c <= close_c) begin
        cnt_next = cnt_inc;
        if (cnt_inc >= cfg.hold_frames) begin
          open_next = 1'b0;
        end
      end else begin
        cnt_next = '0;
      end
      // target is below the gain only when closing on a nonzero gain
      coef_next = (!open_next && gain != '0) ? cfg.fade_out_coef : cfg.fade_in_coef;
    end else begin
      open_next = 1'b1;
      cnt_next  = '0;
    end
  end

  assign load_out = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    mul_a      = {1'b0, coef_r};
    mul_b      = $signed({{(B_W-GAIN_W){1'b0}}, gain}) - tgt_b;
    unique case (state)
      S_IDLE: begin
        mul_a = (q_data.det > env) ? {1'b0, cfg.detector_attack_coef}
                                   : {1'b0, cfg.detector_release_coef};
        mul_b = $signed({{(B_W-SAMPLE_BITS){1'b0}}, env})
              - $signed({{(B_W-SAMPLE_BITS){1'b0}}, q_data.det});
        if (q_valid) begin
          q_ready    = 1'b1;
          state_next = S_ENVUPD;
        end
      end
      S_ENVUPD:  state_next = S_GATE;
      S_GATE:    state_next = S_GAIN;
      S_GAIN:    state_next = S_GAINUPD;
      S_GAINUPD: state_next = S_LEFT;
      S_LEFT: begin
        mul_a      = {1'b0, gain};
        mul_b      = {{(B_W-SAMPLE_BITS){cur.left[SAMPLE_BITS-1]}}, cur.left};
        state_next = S_RIGHT;
      end
      S_RIGHT: begin
        mul_a      = {1'b0, gain};
        mul_b      = {{(B_W-SAMPLE_BITS){cur.right[SAMPLE_BITS-1]}}, cur.right};
        state_next = S_OUT;
      end
      S_OUT: begin
        // keep the right-channel product while the output stalls
        mul_a = {1'b0, gain};
        mul_b = {{(B_W-SAMPLE_BITS){cur.right[SAMPLE_BITS-1]}}, cur.right};
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env       <= '0;
      gain      <= UNITY_GAIN;
      below_cnt <= '0;
      open_flag <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (state == S_ENVUPD) begin
        env <= env_sum[SAMPLE_BITS-1:0];
      end
      if (state == S_GATE) begin
        below_cnt <= cnt_next;
        open_flag <= open_next;
      end
      if (state == S_GAINUPD) begin
        gain <= gain_new;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (state == S_IDLE && q_valid) begin
      cur <= q_data;
    end
    if (state == S_GATE) begin
      tgt_unity <= open_next;
      coef_r    <= coef_next;
    end
    if (state == S_OUT) begin
      lout <= lout;
    end
    if (state == S_RIGHT) begin
      lout <= rs23[SAMPLE_BITS-1:0];
    end
    if (load_out) begin
      out_data.left_out  <= lout;
      out_data.right_out <= rs23[SAMPLE_BITS-1:0];
      out_data.gain_now  <= gain;
      out_data.is_open   <= open_flag;
    end
  end

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    gain <= UNITY_GAIN)
    else $error("gate gain above unity");

  a_bypass_open: assert property (@(posedge clk) disable iff (rst)
    (state == S_GATE && !cfg.gate_enable) |=> open_flag)
    else $error("gate closed while disabled");

  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !out_ready) |=> (state == S_OUT))
    else $error("result overwritten before it was taken");

endmodule

### hdl/stereo_noise_gate_hold_hysteresis.sv
// Stereo noise gate with hysteresis and hold. Each input beat is one stereo
// frame; each frame gives exactly one output beat with both samples scaled by
// the new gate gain (Q1.23), the gain itself and the open flag. The envelope
// follows max(|left|, |right|) with attack/release coefficients (Q0.24);
// levels are linear and compared directly. A front stage takes a frame and
// forms the detector value, a queue of QUEUE_DEPTH entries (two by default)
// decouples it from the back end, and the back end works on one frame at a
// time with its single shared multiplier, which serves in turn the envelope
// step, the gain step and each channel's scaling. An output register holds a
// finished result while the next frame is already being worked on. Registers
// are written through a plain write port; the user must write them only while
// no frame is in flight, and the block itself does not enforce it.
module stereo_noise_gate_hold_hysteresis #(
  parameter logic [sngh_pkg::COEF_W-1:0] BYPASS_COEF = sngh_pkg::BYPASS_COEF_DEF,
  parameter int                          QUEUE_DEPTH = sngh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sngh_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sngh_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [sngh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sngh_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sngh_pkg::*;

  cfg_t  cfg;
  logic  fq_valid;
  logic  fq_ready;
  work_t fq_data;
  logic  bq_valid;
  logic  bq_ready;
  work_t bq_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gate_enable           <= 1'b0;
      cfg.close_level           <= CLOSE_LEVEL_RST;
      cfg.open_level            <= OPEN_LEVEL_RST;
      cfg.hold_frames           <= HOLD_FRAMES_RST;
      cfg.fade_out_coef         <= FADE_OUT_RST;
      cfg.fade_in_coef          <= FADE_IN_RST;
      cfg.detector_attack_coef  <= DET_ATTACK_RST;
      cfg.detector_release_coef <= DET_RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GATE_ENABLE:      cfg.gate_enable           <= cfg_data[0];
        CFG_CLOSE_LEVEL:      cfg.close_level           <= cfg_data[LEVEL_W-1:0];
        CFG_OPEN_LEVEL:       cfg.open_level            <= cfg_data[LEVEL_W-1:0];
        CFG_HOLD_FRAMES:      cfg.hold_frames           <= cfg_data[HOLD_W-1:0];
        CFG_FADE_OUT_COEF:    cfg.fade_out_coef         <= cfg_data[COEF_W-1:0];
        CFG_FADE_IN_COEF:     cfg.fade_in_coef          <= cfg_data[COEF_W-1:0];
        CFG_DET_ATTACK_COEF:  cfg.detector_attack_coef  <= cfg_data[COEF_W-1:0];
        CFG_DET_RELEASE_COEF: cfg.detector_release_coef <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  sngh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  sngh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_data   (bq_data)
  );

  sngh_back #(
    .BYPASS_COEF (BYPASS_COEF)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_data    (bq_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
